// ===== sv/tdls_pkg.sv =====
// Package for the tridiagonal solver: widths, fixed-point helpers, controller
// command/status types. Depends on nothing.
package tdls_pkg;
	localparam int MAX_ROWS   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int CNT_W      = ROW_W + 1;
	localparam int THR_W      = 31;
	localparam int DIVQ_W     = DATA_WIDTH + FRAC_BITS + 1;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [ROW_W-1:0] row_t;

	localparam logic signed [63:0] VMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

	// datapath operations
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_LOAD0  = 3'd1; // store first row
	localparam logic [2:0] OP_FACTOR = 3'd2; // f = a / piv
	localparam logic [2:0] OP_REDUCE = 3'd3; // diag/rhs update
	localparam logic [2:0] OP_XLAST  = 3'd4; // x = rhs / diag of last row
	localparam logic [2:0] OP_BACK   = 3'd5; // t = rhs[k] - upper[k]*x
	localparam logic [2:0] OP_XDIV   = 3'd6; // x = t / diag[k]

	typedef struct packed {
		logic [2:0] op;
		logic       start;   // begin op this cycle
		logic       rd;      // issue memory read at addr
		logic       cap;     // latch the row item being accepted
		row_t       addr;
	} dp_cmd_t;

	typedef struct packed {
		logic done;          // multi-cycle op finished
		logic too_small;     // pivot of last read is under threshold
	} dp_sts_t;

	function automatic data_t sat64(input logic signed [63:0] v);
		if (v > VMAX) return data_t'(VMAX);
		if (v < VMIN) return data_t'(VMIN);
		return data_t'(v);
	endfunction
endpackage

// ===== sv/tdls_if.sv =====
// Valid/ready channel interface used by all ports of the solver.
// Depends on nothing; payload type is a parameter of the interface.
interface tdls_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tridiagonal_linear_solver_unit.sv =====
// Tridiagonal solver top level (Thomas algorithm, Q16.16, saturating).
// A row is accepted only after the previous row is fully processed, which is paced
// by the 48-step serial divider that forms each elimination factor; a row that
// is not last gives no result. After the last row, each further solution value
// is formed only after the previous one is taken (one divide per row of back
// substitution). Results come from the last row to row zero.
// Depends on tdls_pkg, tdls_if, tdls_ctrl, tdls_datapath.
module tridiagonal_linear_solver_unit import tdls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tdls_if.sink   rows,
	tdls_if.sink   cfg,
	tdls_if.source results
);
	logic [THR_W-1:0] thr_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	row_t wr_row, out_row;
	logic out_sing, out_last;
	data_t x;

	// threshold register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THR_W'(1);
		else if (cfg.valid) thr_q <= cfg.data[THR_W-1:0];
	end

	tdls_ctrl u_ctrl (.clk, .arst_n, .in_valid(rows.valid), .in_last(rows.data.last_row),
		.in_ready(rows.ready), .out_valid(results.valid), .out_ready(results.ready),
		.out_sing, .out_last, .out_row, .wr_row, .cmd, .sts);

	tdls_datapath u_dp (.clk, .arst_n, .cmd, .thr(thr_q), .in_a(rows.data.sub_diag),
		.in_b(rows.data.main_diag), .in_c(rows.data.super_diag),
		.in_r(rows.data.rhs_value), .wr_row, .sts, .x_out(x));

	assign results.data.solution_value = out_sing ? '0 : x;
	assign results.data.row_index = out_row;
	assign results.data.singular = out_sing;
	assign results.data.last_result = out_last;
endmodule

// ===== sv/tdls_div.sv =====
// Restoring serial divider for Q-format quotients, one quotient bit a cycle.
// Depends on tdls_pkg.
module tdls_div import tdls_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  data_t num,
	input  data_t den,
	output logic  busy,
	output logic  done,
	output data_t quot
);
	localparam int NW = DATA_WIDTH + FRAC_BITS;
	localparam int SW = $clog2(NW + 1);
	logic [NW-1:0] rem_q, dvd_q;
	logic [DATA_WIDTH-1:0] dabs_q;
	logic neg_q, zero_q, pos_q;
	logic [SW-1:0] cnt_q;
	logic [DATA_WIDTH:0] trial;
	logic [DATA_WIDTH:0] rsh;
	logic signed [63:0] qs;

	// shift one dividend bit into the partial remainder
	assign rsh   = {rem_q[DATA_WIDTH-1:0], dvd_q[NW-1]};
	assign trial = rsh - {1'b0, dabs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy  <= 1'b1;
				cnt_q <= SW'(NW);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SW'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {(num[DATA_WIDTH-1] ? -num : num), {FRAC_BITS{1'b0}}};
			dabs_q <= den[DATA_WIDTH-1] ? -den : den;
			rem_q  <= '0;
			neg_q  <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
			zero_q <= (den == '0);
			pos_q  <= !num[DATA_WIDTH-1];
		end else if (busy) begin
			dvd_q <= {dvd_q[NW-2:0], 1'b0};
			if (!trial[DATA_WIDTH]) begin
				rem_q <= NW'(trial[DATA_WIDTH-1:0]);
				dvd_q <= {dvd_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= NW'(rsh[DATA_WIDTH-1:0]);
			end
		end
	end
	// quotient bits accumulate in dvd_q as the dividend shifts out
	// (|num| fits in DATA_WIDTH bits since -MIN is unsigned here)
	assign qs = neg_q ? -$signed({16'd0, dvd_q}) : $signed({16'd0, dvd_q});
	assign quot = zero_q ? (pos_q ? data_t'(VMAX) : data_t'(VMIN)) : sat64(qs);
endmodule

// ===== sv/tdls_datapath.sv =====
// Datapath: row stores, serial divider, one multiplier, saturating subtract.
// Depends on tdls_pkg and tdls_div.
module tdls_datapath import tdls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  dp_cmd_t cmd,
	input  logic [THR_W-1:0] thr,
	input  data_t in_a,
	input  data_t in_b,
	input  data_t in_c,
	input  data_t in_r,
	input  row_t  wr_row,
	output dp_sts_t sts,
	output data_t x_out
);
	data_t diag_mem [MAX_ROWS];
	data_t up_mem   [MAX_ROWS];
	data_t rhs_mem  [MAX_ROWS];
	data_t d_rd_q, u_rd_q, r_rd_q;
	data_t f_q, x_q, t_q, a_q, b_q, c_q, r_q;
	logic [1:0] ph_q;
	logic done_q;
	logic div_start, div_busy, div_done;
	data_t div_num, div_den, div_q;
	logic signed [63:0] prod_q, shp;
	data_t mul_a, mul_b, mres;
	logic [DATA_WIDTH-1:0] pabs;

	// registered memory reads
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			d_rd_q <= diag_mem[cmd.addr];
			u_rd_q <= up_mem[cmd.addr];
			r_rd_q <= rhs_mem[cmd.addr];
		end
	end

	assign pabs = d_rd_q[DATA_WIDTH-1] ? -d_rd_q : d_rd_q;
	assign sts = '{done: done_q, too_small: (pabs < {1'b0, thr})};

	assign div_start = cmd.start && (cmd.op == OP_FACTOR || cmd.op == OP_XLAST
		|| cmd.op == OP_XDIV);
	assign div_num = (cmd.op == OP_FACTOR) ? a_q : (cmd.op == OP_XLAST) ? r_rd_q : t_q;
	assign div_den = d_rd_q;

	tdls_div u_div (.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .done(div_done), .quot(div_q));

	// multiply operand select: upper*f on the reduce start, rhs*f after it
	always_comb begin
		mul_a = u_rd_q;
		mul_b = x_q;
		if (cmd.op == OP_REDUCE) begin
			mul_a = cmd.start ? u_rd_q : r_rd_q;
			mul_b = f_q;
		end
	end
	assign shp  = prod_q >>> FRAC_BITS;
	assign mres = sat64(shp);

	// operation sequencing inside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && (cmd.op == OP_REDUCE || cmd.op == OP_BACK || cmd.op == OP_LOAD0))
				ph_q <= 2'd0;
			else if (ph_q != 2'd3)
				ph_q <= ph_q + 1'b1;
			if (div_done) done_q <= 1'b1;
			if (cmd.op == OP_LOAD0 && cmd.start) done_q <= 1'b1;
			if (cmd.op == OP_REDUCE && !cmd.start && ph_q == 2'd2) done_q <= 1'b1;
			if (cmd.op == OP_BACK && !cmd.start && ph_q == 2'd1) done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			a_q <= in_a; b_q <= in_b; c_q <= in_c; r_q <= in_r;
		end
		if (div_done && cmd.op == OP_FACTOR) f_q <= div_q;
		if (div_done && (cmd.op == OP_XLAST || cmd.op == OP_XDIV)) x_q <= div_q;
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (cmd.op == OP_BACK && !cmd.start && ph_q == 2'd0)
			t_q <= sat64(64'(r_rd_q) - 64'(mres));
		// stores; the first row always lands at index zero
		if (cmd.op == OP_LOAD0 && cmd.start) begin
			diag_mem[row_t'(0)] <= in_b;
			rhs_mem[row_t'(0)]  <= in_r;
			up_mem[row_t'(0)]   <= in_c;
		end
		if (cmd.op == OP_REDUCE && !cmd.start && ph_q == 2'd0)
			diag_mem[wr_row] <= sat64(64'(b_q) - 64'(mres));
		if (cmd.op == OP_REDUCE && !cmd.start && ph_q == 2'd1) begin
			rhs_mem[wr_row] <= sat64(64'(r_q) - 64'(mres));
			up_mem[wr_row]  <= c_q;
		end
	end
	assign x_out = x_q;
endmodule

// ===== sv/tdls_ctrl.sv =====
// Controller state machine: row loading, pivot checks, back substitution.
// Depends on tdls_pkg.
module tdls_ctrl import tdls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic out_sing,
	output logic out_last,
	output row_t out_row,
	output row_t wr_row,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);
	localparam logic [3:0] S_IDLE = 4'd0, S_PIV = 4'd1, S_FDIV = 4'd2,
		S_RED = 4'd3, S_LRD = 4'd4, S_LCHK = 4'd5, S_XL = 4'd6,
		S_EMIT = 4'd7, S_BRD = 4'd8, S_BMUL = 4'd9, S_BDIV = 4'd10,
		S_BRD2 = 4'd11, S_ST = 4'd12;
	logic [3:0] st_q;
	logic [CNT_W-1:0] cnt_q;
	row_t row_q, k_q;
	logic sing_q, last_q;
	logic acc;

	assign in_ready = (st_q == S_IDLE);
	assign acc = in_valid && in_ready;
	assign wr_row = row_q;
	assign out_valid = (st_q == S_EMIT);
	assign out_sing = sing_q;
	assign out_row = sing_q ? '0 : k_q;
	assign out_last = sing_q || (k_q == '0);

	// command decode
	always_comb begin
		cmd = '0;
		cmd.addr = k_q;
		unique case (st_q)
			S_IDLE: begin
				cmd.rd = acc; cmd.cap = acc; cmd.addr = row_t'(cnt_q - 1'b1);
				cmd.op = (acc && cnt_q == '0) ? OP_LOAD0 : OP_NONE;
				cmd.start = acc && cnt_q == '0;
			end
			S_PIV:  begin cmd.op = OP_FACTOR; cmd.start = 1'b1; end
			// reduce starts as the factor division reports done
			S_FDIV: begin
				cmd.op = sts.done ? OP_REDUCE : OP_FACTOR;
				cmd.start = sts.done;
			end
			S_RED:  begin cmd.op = OP_REDUCE; cmd.addr = row_t'(row_q - 1'b1); end
			S_LRD:  begin cmd.rd = 1'b1; cmd.addr = row_q; end
			S_LCHK: begin cmd.op = OP_XLAST; cmd.start = !sts.too_small && !sing_q; end
			S_XL:   cmd.op = OP_XLAST;
			S_BRD:  begin cmd.rd = 1'b1; end
			S_BRD2: begin cmd.op = OP_BACK; cmd.start = 1'b1; end
			S_BMUL: begin cmd.op = OP_BACK; end
			S_BDIV: begin cmd.op = OP_XDIV; cmd.start = (st_q == S_BDIV) && !last_q; end
			S_ST:   cmd.op = OP_XDIV;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; cnt_q <= '0; row_q <= '0; k_q <= '0;
			sing_q <= 1'b0; last_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (acc) begin
					row_q <= (cnt_q >= CNT_W'(MAX_ROWS - 1)) ? row_t'(MAX_ROWS - 1)
						: row_t'(cnt_q);
					last_q <= in_last || cnt_q >= CNT_W'(MAX_ROWS - 1);
					if (cnt_q == '0) st_q <= (in_last) ? S_LRD : S_IDLE;
					else st_q <= S_PIV;
					if (cnt_q == '0 && !in_last) cnt_q <= CNT_W'(1);
				end
				S_PIV: begin
					if (sts.too_small) sing_q <= 1'b1;
					st_q <= S_FDIV;
				end
				S_FDIV: if (sts.done) st_q <= S_RED;
				S_RED: if (sts.done) begin
					if (last_q) st_q <= S_LRD;
					else begin cnt_q <= cnt_q + 1'b1; st_q <= S_IDLE; end
				end
				S_LRD: begin k_q <= row_q; st_q <= S_LCHK; end
				S_LCHK: begin
					if (sts.too_small) sing_q <= 1'b1;
					st_q <= (sts.too_small || sing_q) ? S_EMIT : S_XL;
				end
				S_XL: if (sts.done) st_q <= S_EMIT;
				S_EMIT: if (out_ready) begin
					if (out_last) begin
						st_q <= S_IDLE; cnt_q <= '0; sing_q <= 1'b0;
					end else begin
						k_q <= k_q - 1'b1; st_q <= S_BRD;
					end
				end
				S_BRD: st_q <= S_BRD2;
				S_BRD2: st_q <= S_BMUL;
				S_BMUL: if (sts.done) begin st_q <= S_BDIV; last_q <= 1'b0; end
				S_BDIV: st_q <= S_ST;
				S_ST: if (sts.done) st_q <= S_EMIT;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(k_q)) else $error("result dropped");
	a_nohs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("load during emit");
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sing_q |-> out_last) else $error("singular not final");
endmodule
